>>> rtl/spie_pkg.sv
// Package: widths, register indexes, item types and internal stage types.
`default_nettype none
package spie_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IO_FRAC = 16;
	localparam int OUT_W = 48;
	localparam int CRD_W = 32;
	localparam int MAG_W = 31;
	localparam int SHINE_W = 18;

	localparam int RAD_W = 64;
	localparam int ROOT_W = 32;
	localparam int REM_W = 35;
	localparam int ISQ_STEPS = 32;

	localparam int Q_W = FRAC_BITS + 1;
	localparam int DIV_STEPS = Q_W;

	localparam int S_W = FRAC_BITS + 3;
	localparam int SM_W = FRAC_BITS + 2;
	localparam int SSQ_W = 2 * SM_W;
	localparam int SLEN_W = FRAC_BITS + 2;
	localparam int GS_W = CRD_W + S_W;
	localparam int DOT_W = GS_W + 2;
	localparam int SGP_W = SHINE_W + ROOT_W + 1;
	localparam int T_W = SGP_W + 1 - IO_FRAC;
	localparam int PROD_W = T_W + SLEN_W + 1;
	localparam int V_W = PROD_W + 1;
	localparam int R_W = V_W + 1 - FRAC_BITS;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	localparam int BACK_LAT = 2 + ISQ_STEPS + DIV_STEPS + 3 + ISQ_STEPS + 2;

	localparam int CFG_ADDR_W = 5;
	localparam int REG_IDX_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [REG_IDX_W-1:0] REG_CAMERA_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CAMERA_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CAMERA_Z = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LIGHT_X = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LIGHT_Y = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LIGHT_Z = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SHINE = 3'd6;

	localparam logic [SHINE_W-1:0] SHINE_RESET = 18'd58982;

	localparam logic signed [63:0] OUT_MAX = 64'sd140737488355327;
	localparam logic signed [63:0] OUT_MIN = -64'sd140737488355328;

	typedef struct packed {
		logic signed [CRD_W-1:0] point_x;
		logic signed [CRD_W-1:0] point_y;
		logic signed [CRD_W-1:0] point_z;
		logic signed [CRD_W-1:0] gradient_x;
		logic signed [CRD_W-1:0] gradient_y;
		logic signed [CRD_W-1:0] gradient_z;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] surface_value;
		logic                    degenerate;
	} out_item_t;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] cmag;
		logic [2:0]            cneg;
		logic [2:0][MAG_W-1:0] lmag;
		logic [2:0]            lneg;
		logic [2:0][CRD_W-1:0] g;
		logic [2:0][CRD_W-1:0] gmag;
	} fr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

>>> rtl/spie_front.sv
// Front stage: direction vectors, magnitudes, range reduction and gradient magnitudes.
`default_nettype none
module spie_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  spie_pkg::in_item_t                    in_item,
	input  logic [2:0][spie_pkg::CRD_W-1:0]       cam,
	input  logic [2:0][spie_pkg::CRD_W-1:0]       lig,
	input  spie_pkg::q_stat_t                     q_stat,
	output logic                                  push,
	output spie_pkg::fr_t                         fr_item
);

	logic                          fr_vld_q;
	spie_pkg::fr_t                 fr_q;
	spie_pkg::fr_t                 fr_c;
	logic                          accept;
	logic [2:0][spie_pkg::CRD_W-1:0] pt;
	logic [2:0][spie_pkg::CRD_W-1:0] gv;
	logic signed [spie_pkg::CRD_W:0] dc [3];
	logic signed [spie_pkg::CRD_W:0] dl [3];
	logic [spie_pkg::CRD_W:0]        mc [3];
	logic [spie_pkg::CRD_W:0]        ml [3];
	logic                            bigc;
	logic                            bigl;

	assign in_stall = fr_vld_q & q_stat.full;
	assign push = fr_vld_q & ~q_stat.full;
	assign accept = in_valid & ~in_stall;
	assign fr_item = fr_q;

	always_comb begin
		pt[0] = in_item.point_x;
		pt[1] = in_item.point_y;
		pt[2] = in_item.point_z;
		gv[0] = in_item.gradient_x;
		gv[1] = in_item.gradient_y;
		gv[2] = in_item.gradient_z;
		bigc = 1'b0;
		bigl = 1'b0;
		for (int i = 0; i < 3; i++) begin
			dc[i] = $signed({cam[i][spie_pkg::CRD_W-1], cam[i]})
				- $signed({pt[i][spie_pkg::CRD_W-1], pt[i]});
			dl[i] = $signed({lig[i][spie_pkg::CRD_W-1], lig[i]})
				- $signed({pt[i][spie_pkg::CRD_W-1], pt[i]});
			mc[i] = dc[i][spie_pkg::CRD_W] ? -dc[i] : dc[i];
			ml[i] = dl[i][spie_pkg::CRD_W] ? -dl[i] : dl[i];
			bigc = bigc | (|mc[i][spie_pkg::CRD_W:spie_pkg::MAG_W]);
			bigl = bigl | (|ml[i][spie_pkg::CRD_W:spie_pkg::MAG_W]);
		end
		for (int i = 0; i < 3; i++) begin
			fr_c.cneg[i] = dc[i][spie_pkg::CRD_W];
			fr_c.lneg[i] = dl[i][spie_pkg::CRD_W];
			fr_c.cmag[i] = bigc ? mc[i][spie_pkg::MAG_W:1] : mc[i][spie_pkg::MAG_W-1:0];
			fr_c.lmag[i] = bigl ? ml[i][spie_pkg::MAG_W:1] : ml[i][spie_pkg::MAG_W-1:0];
			fr_c.g[i] = gv[i];
			fr_c.gmag[i] = gv[i][spie_pkg::CRD_W-1] ? -gv[i] : gv[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_vld_q <= 1'b0;
		end else if (accept) begin
			fr_vld_q <= 1'b1;
		end else if (push) begin
			fr_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fr_q <= fr_c;
		end
	end

endmodule
`default_nettype wire

>>> rtl/spie_queue.sv
// Short item queue between the front stage and the arithmetic pipeline.
`default_nettype none
module spie_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spie_pkg::fr_t     din,
	input  logic              pop,
	output spie_pkg::fr_t     dout,
	output spie_pkg::q_stat_t q_stat
);

	spie_pkg::fr_t                 mem_q [spie_pkg::QUEUE_DEPTH];
	logic [spie_pkg::QPTR_W-1:0]   wr_q;
	logic [spie_pkg::QPTR_W-1:0]   rd_q;
	logic [spie_pkg::QCNT_W-1:0]   cnt_q;

	assign q_stat.full = cnt_q == spie_pkg::QCNT_W'(spie_pkg::QUEUE_DEPTH);
	assign q_stat.empty = cnt_q == '0;
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule
`default_nettype wire

>>> rtl/spie_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module spie_isqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [spie_pkg::RAD_W-1:0]  rad,
	output logic [spie_pkg::ROOT_W-1:0] root
);

	logic [spie_pkg::REM_W-1:0]  rem_q  [spie_pkg::ISQ_STEPS];
	logic [spie_pkg::ROOT_W-1:0] root_q [spie_pkg::ISQ_STEPS];
	logic [spie_pkg::RAD_W-1:0]  rad_q  [spie_pkg::ISQ_STEPS];

	assign root = root_q[spie_pkg::ISQ_STEPS-1];

	for (genvar k = 0; k < spie_pkg::ISQ_STEPS; k++) begin : g_stage
		logic [spie_pkg::REM_W-1:0]  rp;
		logic [spie_pkg::ROOT_W-1:0] rtp;
		logic [spie_pkg::RAD_W-1:0]  dp;
		logic [spie_pkg::REM_W-1:0]  cur;
		logic [spie_pkg::REM_W-1:0]  trial;
		logic                        ge;

		if (k == 0) begin : g_first
			assign rp = '0;
			assign rtp = '0;
			assign dp = rad;
		end else begin : g_next
			assign rp = rem_q[k-1];
			assign rtp = root_q[k-1];
			assign dp = rad_q[k-1];
		end

		assign cur = {rp[spie_pkg::REM_W-3:0], dp[spie_pkg::RAD_W-1 -: 2]};
		assign trial = {1'b0, rtp, 2'b01};
		assign ge = cur >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? cur - trial : cur;
				root_q[k] <= {rtp[spie_pkg::ROOT_W-2:0], ge};
				rad_q[k] <= {dp[spie_pkg::RAD_W-3:0], 2'b00};
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/spie_div.sv
// Pipelined restoring divider for one unit vector component, one quotient bit per stage.
`default_nettype none
module spie_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [spie_pkg::MAG_W-1:0]  mag,
	input  logic [spie_pkg::ROOT_W-1:0] len,
	output logic [spie_pkg::Q_W-1:0]    quo
);

	logic [spie_pkg::ROOT_W-1:0] rem_q [spie_pkg::DIV_STEPS];
	logic [spie_pkg::ROOT_W-1:0] len_q [spie_pkg::DIV_STEPS];
	logic [spie_pkg::Q_W-1:0]    quo_q [spie_pkg::DIV_STEPS];

	assign quo = quo_q[spie_pkg::DIV_STEPS-1];

	for (genvar k = 0; k < spie_pkg::DIV_STEPS; k++) begin : g_stage
		logic [spie_pkg::ROOT_W:0]   cur;
		logic [spie_pkg::ROOT_W-1:0] ln;
		logic [spie_pkg::Q_W-1:0]    qp;
		logic [spie_pkg::ROOT_W:0]   diff;
		logic                        ge;

		if (k == 0) begin : g_first
			assign cur = {{(spie_pkg::ROOT_W + 1 - spie_pkg::MAG_W){1'b0}}, mag};
			assign ln = len;
			assign qp = '0;
		end else begin : g_next
			assign cur = {rem_q[k-1], 1'b0};
			assign ln = len_q[k-1];
			assign qp = quo_q[k-1];
		end

		assign diff = cur - {1'b0, ln};
		assign ge = cur >= {1'b0, ln};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? diff[spie_pkg::ROOT_W-1:0] : cur[spie_pkg::ROOT_W-1:0];
				len_q[k] <= ln;
				quo_q[k] <= {qp[spie_pkg::Q_W-2:0], ge};
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/spie_back.sv
// Arithmetic pipeline: lengths, unit vectors, half vector, dot product and output register.
`default_nettype none
module spie_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  spie_pkg::q_stat_t                q_stat,
	input  spie_pkg::fr_t                    q_head,
	output logic                             pop,
	input  logic [spie_pkg::SHINE_W-1:0]     shine,
	output logic                             out_valid,
	input  logic                             out_stall,
	output spie_pkg::out_item_t              out_item
);

	typedef struct packed {
		logic [2:0][spie_pkg::MAG_W-1:0] cmag;
		logic [2:0]                      cneg;
		logic [2:0][spie_pkg::MAG_W-1:0] lmag;
		logic [2:0]                      lneg;
		logic [2:0][spie_pkg::CRD_W-1:0] g;
	} sa_t;

	typedef struct packed {
		logic [2:0]                       cneg;
		logic [2:0]                       lneg;
		logic [2:0][spie_pkg::CRD_W-1:0]  g;
		logic [spie_pkg::ROOT_W-1:0]      glen;
		logic                             zc;
		logic                             zl;
	} sb_t;

	typedef struct packed {
		logic signed [spie_pkg::DOT_W-1:0] dot;
		logic signed [spie_pkg::T_W-1:0]   t;
		logic                              degen;
	} sd_t;

	localparam logic signed [spie_pkg::SGP_W:0] T_HALF =
		(spie_pkg::SGP_W + 1)'(1) << (spie_pkg::IO_FRAC - 1);
	localparam logic signed [spie_pkg::V_W:0] V_HALF =
		(spie_pkg::V_W + 1)'(1) << (spie_pkg::FRAC_BITS - 1);

	logic [spie_pkg::BACK_LAT-1:0] vld_q;
	logic                          adv;

	logic [2*spie_pkg::MAG_W-1:0]  sqc_s1 [3];
	logic [2*spie_pkg::MAG_W-1:0]  sql_s1 [3];
	logic [2*spie_pkg::CRD_W-1:0]  sqg_s1 [3];
	sa_t                           sa_s1;

	logic [spie_pkg::RAD_W-1:0]    sumc_s2;
	logic [spie_pkg::RAD_W-1:0]    suml_s2;
	logic [spie_pkg::RAD_W-1:0]    sumg_s2;
	sa_t                           sa_s2;

	logic [spie_pkg::ROOT_W-1:0]   lenc;
	logic [spie_pkg::ROOT_W-1:0]   lenl;
	logic [spie_pkg::ROOT_W-1:0]   glen;
	sa_t                           sa_q [spie_pkg::ISQ_STEPS];
	sa_t                           sa_end;

	logic [spie_pkg::Q_W-1:0]      quoc [3];
	logic [spie_pkg::Q_W-1:0]      quol [3];
	sb_t                           sb_q [spie_pkg::DIV_STEPS];
	sb_t                           sb_in;
	sb_t                           sb_end;

	logic signed [spie_pkg::S_W-1:0]   s_c [3];
	logic signed [spie_pkg::S_W-1:0]   s_s3 [3];
	logic [2:0][spie_pkg::CRD_W-1:0]   g_s3;
	logic [spie_pkg::ROOT_W-1:0]       glen_s3;
	logic                              degen_s3;

	logic [spie_pkg::SM_W-1:0]         sm_c [3];
	logic [spie_pkg::SSQ_W-1:0]        ssq_s4 [3];
	logic signed [spie_pkg::GS_W-1:0]  gs_s4 [3];
	logic signed [spie_pkg::SGP_W-1:0] sg_s4;
	logic                              degen_s4;

	logic [spie_pkg::RAD_W-1:0]        ssum_c;
	logic signed [spie_pkg::DOT_W-1:0] dot_c;
	logic signed [spie_pkg::SGP_W:0]   tr_c;
	logic [spie_pkg::RAD_W-1:0]        ssum_s5;
	sd_t                               sd_s5;

	logic [spie_pkg::ROOT_W-1:0]       slen;
	sd_t                               sd_q [spie_pkg::ISQ_STEPS];
	sd_t                               sd_end;

	logic signed [spie_pkg::PROD_W-1:0] prod_c;
	logic signed [spie_pkg::PROD_W-1:0] prod_s6;
	logic signed [spie_pkg::DOT_W-1:0]  dot_s6;
	logic                               degen_s6;

	logic signed [spie_pkg::V_W-1:0]    v_c;
	logic signed [spie_pkg::V_W:0]      vr_c;
	logic signed [spie_pkg::R_W-1:0]    r_c;
	logic signed [63:0]                 r64_c;
	spie_pkg::out_item_t                res_c;
	spie_pkg::out_item_t                out_q;

	assign out_valid = vld_q[spie_pkg::BACK_LAT-1];
	assign out_item = out_q;
	assign adv = ~out_valid | ~out_stall;
	assign pop = adv & ~q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[spie_pkg::BACK_LAT-2:0], pop};
		end
	end

	// squares and sums of squares
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sqc_s1[i] <= q_head.cmag[i] * q_head.cmag[i];
				sql_s1[i] <= q_head.lmag[i] * q_head.lmag[i];
				sqg_s1[i] <= q_head.gmag[i] * q_head.gmag[i];
			end
			sa_s1.cmag <= q_head.cmag;
			sa_s1.cneg <= q_head.cneg;
			sa_s1.lmag <= q_head.lmag;
			sa_s1.lneg <= q_head.lneg;
			sa_s1.g <= q_head.g;
			sumc_s2 <= sqc_s1[0] + sqc_s1[1] + sqc_s1[2];
			suml_s2 <= sql_s1[0] + sql_s1[1] + sql_s1[2];
			sumg_s2 <= sqg_s1[0] + sqg_s1[1] + sqg_s1[2];
			sa_s2 <= sa_s1;
		end
	end

	spie_isqrt u_sqrt_c (.clk(clk), .en(adv), .rad(sumc_s2), .root(lenc));
	spie_isqrt u_sqrt_l (.clk(clk), .en(adv), .rad(suml_s2), .root(lenl));
	spie_isqrt u_sqrt_g (.clk(clk), .en(adv), .rad(sumg_s2), .root(glen));

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_q[0] <= sa_s2;
			for (int k = 1; k < spie_pkg::ISQ_STEPS; k++) begin
				sa_q[k] <= sa_q[k-1];
			end
		end
	end
	assign sa_end = sa_q[spie_pkg::ISQ_STEPS-1];

	for (genvar i = 0; i < 3; i++) begin : g_div
		spie_div u_div_c (
			.clk(clk), .en(adv), .mag(sa_end.cmag[i]), .len(lenc), .quo(quoc[i])
		);
		spie_div u_div_l (
			.clk(clk), .en(adv), .mag(sa_end.lmag[i]), .len(lenl), .quo(quol[i])
		);
	end

	always_comb begin
		sb_in.cneg = sa_end.cneg;
		sb_in.lneg = sa_end.lneg;
		sb_in.g = sa_end.g;
		sb_in.glen = glen;
		sb_in.zc = lenc == '0;
		sb_in.zl = lenl == '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_q[0] <= sb_in;
			for (int k = 1; k < spie_pkg::DIV_STEPS; k++) begin
				sb_q[k] <= sb_q[k-1];
			end
		end
	end
	assign sb_end = sb_q[spie_pkg::DIV_STEPS-1];

	// half vector
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [spie_pkg::S_W-1:0] uc;
			logic signed [spie_pkg::S_W-1:0] ul;
			uc = sb_end.zc ? '0 : $signed(spie_pkg::S_W'(quoc[i]));
			ul = sb_end.zl ? '0 : $signed(spie_pkg::S_W'(quol[i]));
			if (sb_end.cneg[i]) begin
				uc = -uc;
			end
			if (sb_end.lneg[i]) begin
				ul = -ul;
			end
			s_c[i] = uc + ul;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s3 <= s_c;
			g_s3 <= sb_end.g;
			glen_s3 <= sb_end.glen;
			degen_s3 <= sb_end.zc | sb_end.zl;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [spie_pkg::S_W-1:0] sa;
			sa = s_s3[i][spie_pkg::S_W-1] ? -s_s3[i] : s_s3[i];
			sm_c[i] = sa[spie_pkg::SM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ssq_s4[i] <= sm_c[i] * sm_c[i];
				gs_s4[i] <= $signed(g_s3[i]) * s_s3[i];
			end
			sg_s4 <= $signed(shine) * $signed({1'b0, glen_s3});
			degen_s4 <= degen_s3;
		end
	end

	always_comb begin
		ssum_c = ssq_s4[0] + ssq_s4[1] + ssq_s4[2];
		dot_c = gs_s4[0] + gs_s4[1] + gs_s4[2];
		tr_c = sg_s4 + T_HALF;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ssum_s5 <= ssum_c;
			sd_s5.dot <= dot_c;
			sd_s5.t <= tr_c[spie_pkg::SGP_W:spie_pkg::IO_FRAC];
			sd_s5.degen <= degen_s4;
		end
	end

	spie_isqrt u_sqrt_s (.clk(clk), .en(adv), .rad(ssum_s5), .root(slen));

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_q[0] <= sd_s5;
			for (int k = 1; k < spie_pkg::ISQ_STEPS; k++) begin
				sd_q[k] <= sd_q[k-1];
			end
		end
	end
	assign sd_end = sd_q[spie_pkg::ISQ_STEPS-1];

	assign prod_c = sd_end.t * $signed({1'b0, slen[spie_pkg::SLEN_W-1:0]});

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s6 <= prod_c;
			dot_s6 <= sd_end.dot;
			degen_s6 <= sd_end.degen;
		end
	end

	// round, saturate
	always_comb begin
		v_c = dot_s6 - prod_s6;
		vr_c = v_c + V_HALF;
		r_c = vr_c[spie_pkg::V_W:spie_pkg::FRAC_BITS];
		r64_c = r_c;
		if (r64_c > spie_pkg::OUT_MAX) begin
			res_c.surface_value = spie_pkg::OUT_MAX[spie_pkg::OUT_W-1:0];
		end else if (r64_c < spie_pkg::OUT_MIN) begin
			res_c.surface_value = spie_pkg::OUT_MIN[spie_pkg::OUT_W-1:0];
		end else begin
			res_c.surface_value = r64_c[spie_pkg::OUT_W-1:0];
		end
		res_c.degenerate = degen_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res_c;
		end
	end

endmodule
`default_nettype wire

>>> rtl/specular_implicit_evaluator.sv
// Top level: configuration registers, front stage, item queue and arithmetic pipeline.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   in_item  (point, gradient)
//  out      output     out_valid / out_stall out_item (surface_value, degenerate)
//  cfg      input      APB psel/penable      7 registers at 4*i
//
// One item per cycle sustained while the output is not stalled. An item passes the
// front register, the queue and the arithmetic pipeline, whose depth is set by the
// 32-stage square root units and the 17-stage dividers. Reset clears valids, queue
// pointers and the camera and light registers. A stalled output freezes the arithmetic
// pipeline; the queue and front stage keep taking items until the queue fills.
`default_nettype none
module specular_implicit_evaluator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [spie_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [spie_pkg::PDATA_W-1:0]      pwdata,
	output logic [spie_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  spie_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output spie_pkg::out_item_t               out_item
);

	logic [2:0][spie_pkg::CRD_W-1:0] cam_q;
	logic [2:0][spie_pkg::CRD_W-1:0] lig_q;
	logic [spie_pkg::SHINE_W-1:0]    shine_q;
	logic [spie_pkg::REG_IDX_W-1:0]  idx;
	logic                            wr_en;

	spie_pkg::q_stat_t q_stat;
	spie_pkg::fr_t     fr_item;
	spie_pkg::fr_t     q_head;
	logic              push;
	logic              pop;

	assign pready = 1'b1;
	assign idx = paddr[spie_pkg::CFG_ADDR_W-1:2];
	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q <= '0;
			lig_q <= '0;
			shine_q <= spie_pkg::SHINE_RESET;
		end else if (wr_en) begin
			unique case (idx)
				spie_pkg::REG_CAMERA_X: cam_q[0] <= pwdata;
				spie_pkg::REG_CAMERA_Y: cam_q[1] <= pwdata;
				spie_pkg::REG_CAMERA_Z: cam_q[2] <= pwdata;
				spie_pkg::REG_LIGHT_X:  lig_q[0] <= pwdata;
				spie_pkg::REG_LIGHT_Y:  lig_q[1] <= pwdata;
				spie_pkg::REG_LIGHT_Z:  lig_q[2] <= pwdata;
				spie_pkg::REG_SHINE:    shine_q <= pwdata[spie_pkg::SHINE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			spie_pkg::REG_CAMERA_X: prdata = cam_q[0];
			spie_pkg::REG_CAMERA_Y: prdata = cam_q[1];
			spie_pkg::REG_CAMERA_Z: prdata = cam_q[2];
			spie_pkg::REG_LIGHT_X:  prdata = lig_q[0];
			spie_pkg::REG_LIGHT_Y:  prdata = lig_q[1];
			spie_pkg::REG_LIGHT_Z:  prdata = lig_q[2];
			spie_pkg::REG_SHINE:
				prdata = {{(spie_pkg::PDATA_W - spie_pkg::SHINE_W){1'b0}}, shine_q};
			default: prdata = '0;
		endcase
	end

	spie_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.cam(cam_q),
		.lig(lig_q),
		.q_stat(q_stat),
		.push(push),
		.fr_item(fr_item)
	);

	spie_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(fr_item),
		.pop(pop),
		.dout(q_head),
		.q_stat(q_stat)
	);

	spie_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.q_head(q_head),
		.pop(pop),
		.shine(shine_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

endmodule
`default_nettype wire

>>> rtl/spie_checker.sv
// Port checker for the evaluator and its bind statement.
`default_nettype none
module spie_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  spie_pkg::out_item_t               out_item
);

	localparam int MAX_PEND = 2 + spie_pkg::QUEUE_DEPTH + spie_pkg::BACK_LAT;

	logic [7:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc = in_valid & ~in_stall;
	assign out_acc = out_valid & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_item))
		else $error("output item changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 8'd0)
		else $error("result without a pending item");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 8'(MAX_PEND))
		else $error("more items in flight than the pipeline holds");

endmodule

bind specular_implicit_evaluator spie_checker u_spie_checker (.*);
`default_nettype wire

>>> sim/tb_top.sv
// Testbench for the specular implicit evaluator: directed table, random items, scoreboard.
`timescale 1ns / 1ps
module tb_top;

	typedef longint vec3_t [0:2];

	typedef struct {
		spie_pkg::in_item_t  item;
		bit                  typed;
		spie_pkg::out_item_t result;
	} stim_row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [spie_pkg::CFG_ADDR_W-1:0] paddr;
	logic [spie_pkg::PDATA_W-1:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_stall, out_valid, out_stall;
	spie_pkg::in_item_t in_item;
	spie_pkg::out_item_t out_item;

	specular_implicit_evaluator dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = spie_pkg::BACK_LAT + 20;

	logic signed [spie_pkg::CRD_W-1:0] cam_r [0:2];
	logic signed [spie_pkg::CRD_W-1:0] lig_r [0:2];
	logic [spie_pkg::SHINE_W-1:0] shine_r;

	spie_pkg::out_item_t pending_q [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit quiet = 0;
	bit hold_req = 0;
	stim_row_t reset_rows [0:2];
	spie_pkg::in_item_t edge_rows [0:9];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic bit unit_dir(input vec3_t tgt, input vec3_t pt, output vec3_t u);
		longint unsigned mag [0:2];
		bit neg [0:2];
		bit big;
		longint unsigned sum, len;
		longint d, q;
		big = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			d = tgt[i] - pt[i];
			neg[i] = d < 0;
			mag[i] = neg[i] ? -d : d;
			if (mag[i] >= (64'd1 << 31)) big = 1;
		end
		for (int i = 0; i < 3; i++) begin
			if (big) mag[i] = mag[i] >> 1;
			sum += mag[i] * mag[i];
		end
		len = root64(sum);
		for (int i = 0; i < 3; i++) begin
			q = 0;
			if (len != 0) q = longint'((mag[i] << spie_pkg::FRAC_BITS) / len);
			u[i] = neg[i] ? -q : q;
		end
		return len == 0;
	endfunction

	function automatic spie_pkg::out_item_t calc_specular(spie_pkg::in_item_t it);
		vec3_t pt, g, cam, lig, uc, ul;
		longint s, dot, shine, t, v, r;
		longint unsigned sm, gm, ssum, gsum, glen, slen;
		bit degen;
		spie_pkg::out_item_t o;
		pt[0] = it.point_x; pt[1] = it.point_y; pt[2] = it.point_z;
		g[0] = it.gradient_x; g[1] = it.gradient_y; g[2] = it.gradient_z;
		for (int i = 0; i < 3; i++) begin
			cam[i] = cam_r[i];
			lig[i] = lig_r[i];
		end
		shine = longint'($signed(shine_r));
		degen = unit_dir(cam, pt, uc);
		degen = unit_dir(lig, pt, ul) | degen;
		dot = 0;
		ssum = 0;
		gsum = 0;
		for (int i = 0; i < 3; i++) begin
			s = uc[i] + ul[i];
			sm = s < 0 ? -s : s;
			ssum += sm * sm;
			gm = g[i] < 0 ? -g[i] : g[i];
			gsum += gm * gm;
			dot += g[i] * s;
		end
		glen = root64(gsum);
		slen = root64(ssum);
		t = (shine * longint'(glen) + (64'sd1 <<< (spie_pkg::IO_FRAC - 1)))
			>>> spie_pkg::IO_FRAC;
		v = dot - t * longint'(slen);
		r = (v + (64'sd1 <<< (spie_pkg::FRAC_BITS - 1))) >>> spie_pkg::FRAC_BITS;
		if (r > spie_pkg::OUT_MAX) r = spie_pkg::OUT_MAX;
		if (r < spie_pkg::OUT_MIN) r = spie_pkg::OUT_MIN;
		o.surface_value = r[spie_pkg::OUT_W-1:0];
		o.degenerate = degen;
		return o;
	endfunction

	task automatic write_reg(input logic [spie_pkg::REG_IDX_W-1:0] idx,
			input logic [31:0] data);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= spie_pkg::CFG_ADDR_W'(idx) << 2;
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		if (idx <= spie_pkg::REG_CAMERA_Z) cam_r[idx] = data;
		else if (idx <= spie_pkg::REG_LIGHT_Z) lig_r[idx - spie_pkg::REG_LIGHT_X] = data;
		else if (idx == spie_pkg::REG_SHINE) shine_r = data[spie_pkg::SHINE_W-1:0];
	endtask

	task automatic drain;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_config(input logic [31:0] c [0:2], input logic [31:0] l [0:2],
			input logic [31:0] sh);
		drain();
		write_reg(spie_pkg::REG_CAMERA_X, c[0]);
		write_reg(spie_pkg::REG_CAMERA_Y, c[1]);
		write_reg(spie_pkg::REG_CAMERA_Z, c[2]);
		write_reg(spie_pkg::REG_LIGHT_X, l[0]);
		write_reg(spie_pkg::REG_LIGHT_Y, l[1]);
		write_reg(spie_pkg::REG_LIGHT_Z, l[2]);
		write_reg(spie_pkg::REG_SHINE, sh);
	endtask

	task automatic send(input spie_pkg::in_item_t it, input bit typed,
			input spie_pkg::out_item_t result);
		if (!quiet && $urandom_range(3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(14, 1)) @(posedge clk);
		end
		in_valid <= 1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		pending_q.push_back(typed ? result : calc_specular(it));
	endtask

	function automatic logic [31:0] rand_coord();
		unique case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
			2: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
			default: return $urandom_range(32'h0000_2000) - 32'h0000_1000;
		endcase
	endfunction

	function automatic spie_pkg::in_item_t rand_item();
		spie_pkg::in_item_t it;
		it.point_x = rand_coord();
		it.point_y = rand_coord();
		it.point_z = rand_coord();
		it.gradient_x = rand_coord();
		it.gradient_y = rand_coord();
		it.gradient_z = rand_coord();
		if ($urandom_range(15) == 0) begin
			it.point_x = cam_r[0];
			it.point_y = cam_r[1];
			it.point_z = cam_r[2];
		end else if ($urandom_range(15) == 0) begin
			it.point_x = lig_r[0];
			it.point_y = lig_r[1];
			it.point_z = lig_r[2];
		end
		return it;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else if (hold_req) begin
			out_stall <= 1;
			repeat (300) @(posedge clk);
			hold_req = 0;
			out_stall <= 0;
		end else if (quiet || $urandom_range(2) != 0) begin
			out_stall <= 0;
			repeat ($urandom_range(20, 1)) @(posedge clk);
		end else begin
			out_stall <= 1;
			repeat ($urandom_range(14, 1)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		spie_pkg::out_item_t want;
		if (out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item: %h", out_item);
			end else begin
				want = pending_q.pop_front();
				if (want.surface_value !== out_item.surface_value
						|| want.degenerate !== out_item.degenerate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp value %0d degen %b, got value %0d degen %b",
							want.surface_value, want.degenerate,
							out_item.surface_value, out_item.degenerate);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [31:0] c [0:2];
		logic [31:0] l [0:2];
		logic [31:0] sh;
		spie_pkg::out_item_t none;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_valid = 0; in_item = '0; out_stall = 0;
		for (int i = 0; i < 3; i++) begin
			cam_r[i] = 0;
			lig_r[i] = 0;
		end
		shine_r = spie_pkg::SHINE_RESET;
		none = '0;

		reset_rows[0] = '{'0, 1, '{surface_value: '0, degenerate: 1'b1}};
		reset_rows[1] = '{'{0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1,
			'{surface_value: '0, degenerate: 1'b1}};
		reset_rows[2] = '{'{0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1,
			'{surface_value: '0, degenerate: 1'b1}};
		edge_rows[0] = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0001_0000, 0, 0};
		edge_rows[1] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 32'h0001_0000, 0};
		edge_rows[2] = '{32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff};
		edge_rows[3] = '{32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 0};
		edge_rows[4] = '{0, 32'h0001_0000, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		edge_rows[5] = '{0, 0, 0, 0, 0, 0};
		edge_rows[6] = '{0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
		edge_rows[7] = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff};
		edge_rows[8] = '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1, 1, 1};
		edge_rows[9] = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000};

		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (reset_rows[i]) send(reset_rows[i].item, reset_rows[i].typed, reset_rows[i].result);
		in_valid <= 0;

		c = '{32'h0001_0000, 0, 0};
		l = '{0, 32'h0001_0000, 0};
		load_config(c, l, 32'd58982);
		foreach (edge_rows[i]) send(edge_rows[i], 0, none);
		in_valid <= 0;
		c = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
		l = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		load_config(c, l, 32'h0001_0000);
		foreach (edge_rows[i]) send(edge_rows[i], 0, none);
		in_valid <= 0;
		drain();
		write_reg(spie_pkg::REG_SHINE, 32'hfffe_0000);
		write_reg(3'd7, 32'hdead_beef);
		foreach (edge_rows[i]) send(edge_rows[i], 0, none);

		for (int phase = 0; phase < 5; phase++) begin
			in_valid <= 0;
			for (int i = 0; i < 3; i++) begin
				c[i] = rand_coord();
				l[i] = rand_coord();
			end
			unique case (phase)
				0: sh = $urandom_range(131072) - 65536;
				1: sh = 32'hffff_0000;
				2: sh = $urandom;
				default: sh = $urandom_range(65536);
			endcase
			load_config(c, l, sh);
			if (phase == 4) quiet = 1;
			for (int n = 0; n < 220; n++) begin
				if (phase == 1 && n == 40) hold_req = 1;
				send(rand_item(), 0, none);
			end
		end
		in_valid <= 0;

		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

>>> specular_implicit_evaluator.f
rtl/spie_pkg.sv
rtl/spie_front.sv
rtl/spie_queue.sv
rtl/spie_isqrt.sv
rtl/spie_div.sv
rtl/spie_back.sv
rtl/specular_implicit_evaluator.sv
rtl/spie_checker.sv
sim/tb_top.sv
